// ===== design/bet_pkg.sv =====
// package for the button edge/hold tracker: sizes, operation, phase and state codes,
// request/response beat structs and controller command/status structs
// no dependencies
package bet_pkg;

	localparam int NUM_BUTTONS = 16;
	localparam int NUM_KEYS    = 128;
	localparam int TIMER_WIDTH = 32;
	localparam int COUNT_WIDTH = 4;

	localparam int BTN_AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [2:0] {
		OP_KEY      = 3'd0,
		OP_TICK     = 3'd1,
		OP_CPRESS   = 3'd2,
		OP_CRELEASE = 3'd3,
		OP_BIND     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE          = 2'd0,
		PH_JUST_PRESSED  = 2'd1,
		PH_HELD          = 2'd2,
		PH_JUST_RELEASED = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [6:0]  key_code;
		logic        is_pressed;
		logic [3:0]  button_index;
		logic [15:0] elapsed_time;
		logic [31:0] hold_threshold;
		logic [15:0] binding_mask;
	} req_t;

	typedef struct packed {
		logic        consumed;
		logic [1:0]  button_phase;
		logic [31:0] held_time;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_WALK   = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

	typedef struct packed {
		logic capture;
		logic bind_wr;
		logic walk_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req_op;
		logic       walk_last;
		logic       out_free;
	} status_t;

endpackage

// ===== design/button_edge_hold_tracker.sv =====
// button edge/hold tracker top level: controller plus datapath
// key events and ticks pass accept, a walk over all NUM_BUTTONS buttons (one button per cycle) and finish;
// consume operations, binding writes and unused codes go from accept straight to finish
// one item at a time; the response register lets the next item start while a beat waits
// arst_n clears all phases, counts, timers and binding valid bits at once; no clearing pass
module button_edge_hold_tracker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bet_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bet_pkg::rsp_t rsp
);
	import bet_pkg::*;

	cmd_t    cmd;
	status_t sts;

	bet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bet_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

`ifndef SYNTH
	// after a beat is taken the block stalls requests in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted on back-to-back cycles");

	a_rsp_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.load_out))
		else $error("response valid without a finish step");

	// idle buttons always carry a cleared timer
	a_idle_timer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.button_phase == PH_IDLE |-> rsp.held_time == 32'd0)
		else $error("idle button with nonzero held time");

	a_consume_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.consumed |->
			rsp.button_phase == PH_HELD || rsp.button_phase == PH_IDLE)
		else $error("successful consume left a transient phase");
`endif

endmodule

// ===== design/bet_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/bet_ctrl.sv =====
// controller state machine for the button tracker: accept, button walk, finish
// depends on bet_pkg
module bet_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  bet_pkg::status_t sts,
	output bet_pkg::cmd_t    cmd
);
	import bet_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (sts.req_op == OP_KEY || sts.req_op == OP_TICK) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_WALK: begin
				if (sts.walk_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
				cmd.bind_wr = req_valid && (sts.req_op == OP_BIND);
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== design/bet_dp.sv =====
// datapath for the button tracker: key binding ram, per-button phase/count/timer
// registers, walk counter and the response register; depends on bet_pkg, bet_ram
module bet_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  bet_pkg::req_t    req,
	input  bet_pkg::cmd_t    cmd,
	output bet_pkg::status_t sts,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output bet_pkg::rsp_t    rsp
);
	import bet_pkg::*;

	localparam int SUM_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH + 1 : 17;
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	req_t                    item_q;
	logic [BTN_AW-1:0]       btn_q;
	logic [NUM_KEYS-1:0]     kvld_q;
	logic [NUM_BUTTONS-1:0]  ram_rdata;
	logic [NUM_BUTTONS-1:0]  mask;
	phase_t                  phase_q [NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0]  cnt_q   [NUM_BUTTONS];
	logic [TIMER_WIDTH-1:0]  tmr_q   [NUM_BUTTONS];
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    req_key_ok, item_key_ok;
	logic [KEY_AW-1:0]       req_kidx, item_kidx;

	// walk datapath
	phase_t                  w_ph, w_ph_n;
	logic [COUNT_WIDTH-1:0]  w_cnt, w_cnt_n;
	logic [TIMER_WIDTH-1:0]  w_tmr, w_tmr_n;
	logic [SUM_W-1:0]        w_sum;

	// finish datapath
	logic [BTN_AW-1:0]       f_idx;
	logic                    f_vb, f_ok;
	phase_t                  f_ph, f_ph_n;
	logic [TIMER_WIDTH-1:0]  f_tmr, f_tmr_n;

	assign req_kidx    = req.key_code[KEY_AW-1:0];
	assign item_kidx   = item_q.key_code[KEY_AW-1:0];
	assign req_key_ok  = 32'(req.key_code) < NUM_KEYS;
	assign item_key_ok = 32'(item_q.key_code) < NUM_KEYS;

	bet_ram #(
		.WIDTH(NUM_BUTTONS),
		.DEPTH(NUM_KEYS)
	) u_bind_ram (
		.clk    (clk),
		.wr_en  (cmd.bind_wr && req_key_ok),
		.wr_addr(req_kidx),
		.wr_data(req.binding_mask[NUM_BUTTONS-1:0]),
		.rd_en  (cmd.capture),
		.rd_addr(req_kidx),
		.rd_data(ram_rdata)
	);

	// an entry never bound reads as no buttons
	assign mask = (item_key_ok && kvld_q[item_kidx]) ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kvld_q <= '0;
		end else if (cmd.bind_wr && req_key_ok) begin
			kvld_q[req_kidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q <= '0;
		end else if (cmd.capture) begin
			btn_q <= '0;
		end else if (cmd.walk_step) begin
			btn_q <= btn_q + 1'b1;
		end
	end

	always_comb begin
		w_ph    = phase_q[btn_q];
		w_cnt   = cnt_q[btn_q];
		w_tmr   = tmr_q[btn_q];
		w_ph_n  = w_ph;
		w_cnt_n = w_cnt;
		w_tmr_n = w_tmr;
		w_sum   = SUM_W'(w_tmr) + SUM_W'(item_q.elapsed_time);
		if (item_q.operation == OP_KEY) begin
			if (mask[btn_q]) begin
				if (item_q.is_pressed) begin
					if (w_cnt != COUNT_MAX) begin
						w_cnt_n = w_cnt + 1'b1;
					end
					if (w_ph == PH_IDLE) begin
						w_ph_n = PH_JUST_PRESSED;
					end
				end else if (w_cnt != '0) begin
					w_cnt_n = w_cnt - 1'b1;
					if (w_cnt_n == '0) begin
						w_ph_n = PH_JUST_RELEASED;
					end
				end
			end
		end else begin
			case (w_ph)
				PH_JUST_PRESSED: w_ph_n = PH_HELD;
				PH_HELD: begin
					if (w_sum > SUM_W'(TIMER_MAX)) begin
						w_tmr_n = TIMER_MAX;
					end else begin
						w_tmr_n = w_sum[TIMER_WIDTH-1:0];
					end
				end
				PH_JUST_RELEASED: begin
					w_ph_n  = PH_IDLE;
					w_tmr_n = '0;
				end
				default: w_ph_n = w_ph;
			endcase
		end
	end

	always_comb begin
		f_idx   = item_q.button_index[BTN_AW-1:0];
		f_vb    = 32'(item_q.button_index) < NUM_BUTTONS;
		f_ph    = phase_q[f_idx];
		f_tmr   = tmr_q[f_idx];
		f_ok    = 1'b0;
		f_ph_n  = f_ph;
		f_tmr_n = f_tmr;
		case (item_q.operation)
			OP_CPRESS: begin
				if (f_vb && f_ph == PH_JUST_PRESSED) begin
					f_ok   = 1'b1;
					f_ph_n = PH_HELD;
				end
			end
			OP_CRELEASE: begin
				if (f_vb && f_ph == PH_JUST_RELEASED &&
				    64'(f_tmr) >= 64'(item_q.hold_threshold)) begin
					f_ok    = 1'b1;
					f_ph_n  = PH_IDLE;
					f_tmr_n = '0;
				end
			end
			default: f_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				phase_q[i] <= PH_IDLE;
				cnt_q[i]   <= '0;
				tmr_q[i]   <= '0;
			end
		end else if (cmd.walk_step) begin
			phase_q[btn_q] <= w_ph_n;
			cnt_q[btn_q]   <= w_cnt_n;
			tmr_q[btn_q]   <= w_tmr_n;
		end else if (cmd.load_out && f_ok) begin
			phase_q[f_idx] <= f_ph_n;
			tmr_q[f_idx]   <= f_tmr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.consumed     <= f_ok;
			rsp_q.button_phase <= f_vb ? f_ph_n : PH_IDLE;
			rsp_q.held_time    <= f_vb ? 32'(f_tmr_n) : 32'd0;
		end
	end

	assign sts.req_op    = req.operation;
	assign sts.walk_last = 32'(btn_q) == NUM_BUTTONS - 1;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/sv/tb_button_edge_hold_tracker.sv =====
`timescale 1ns / 100ps
// self-checking bench for button_edge_hold_tracker: a directed table, then random beats
// checked against an in-bench tracker of phases, counts and held timers
// depends on bet_pkg and the button_edge_hold_tracker rtl
module tb_button_edge_hold_tracker;
	import bet_pkg::*;

	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int RANDOM_BEATS = 800;
	localparam int HOLD_TICKS = 4;
	localparam logic [31:0] HOLD_TIME = 32'(HOLD_TICKS * 65535);
	localparam int CYCLE_LIMIT = 5_000_000;

	typedef struct packed {
		req_t beat;
		int   reps;
		bit   typed;
		rsp_t want;
	} row_t;

	typedef enum {FLOW_FREE, FLOW_SPARSE, FLOW_TOGGLE, FLOW_HEAVY} flow_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// tracked state of the block
	logic [NUM_BUTTONS-1:0] bind_tab [NUM_KEYS];
	phase_t                 btn_ph   [NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0] btn_cnt  [NUM_BUTTONS];
	logic [TIMER_WIDTH-1:0] btn_tmr  [NUM_BUTTONS];

	rsp_t due_rsp [$];
	row_t script [$];
	logic [6:0] hot_keys [8];
	int burst_left = 0;
	int mismatches = 0;
	int cycles = 0;
	flow_t flow = FLOW_FREE;
	int flow_left = 0;

	button_edge_hold_tracker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic rsp_t apply_beat(input req_t r);
		rsp_t o;
		logic [NUM_BUTTONS-1:0] m;
		logic [TIMER_WIDTH:0] sum;
		o = '0;
		case (r.operation)
		OP_KEY: begin
			m = bind_tab[r.key_code];
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				if (m[b] && r.is_pressed) begin
					if (btn_cnt[b] != '1)
						btn_cnt[b]++;
					if (btn_ph[b] == PH_IDLE)
						btn_ph[b] = PH_JUST_PRESSED;
				end else if (m[b] && btn_cnt[b] != '0) begin
					btn_cnt[b]--;
					// timer is kept until the button goes idle
					if (btn_cnt[b] == '0)
						btn_ph[b] = PH_JUST_RELEASED;
				end
			end
		end
		OP_TICK: begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				case (btn_ph[b])
				PH_JUST_PRESSED: btn_ph[b] = PH_HELD;
				PH_HELD: begin
					sum = {1'b0, btn_tmr[b]} + r.elapsed_time;
					btn_tmr[b] = sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];
				end
				PH_JUST_RELEASED: begin
					btn_ph[b] = PH_IDLE;
					btn_tmr[b] = '0;
				end
				default: ;
				endcase
			end
		end
		OP_CPRESS: begin
			if (btn_ph[r.button_index] == PH_JUST_PRESSED) begin
				btn_ph[r.button_index] = PH_HELD;
				o.consumed = 1'b1;
			end
		end
		OP_CRELEASE: begin
			if (btn_ph[r.button_index] == PH_JUST_RELEASED &&
			    btn_tmr[r.button_index] >= r.hold_threshold) begin
				btn_ph[r.button_index] = PH_IDLE;
				btn_tmr[r.button_index] = '0;
				o.consumed = 1'b1;
			end
		end
		OP_BIND: bind_tab[r.key_code] = r.binding_mask;
		default: ;
		endcase
		o.button_phase = btn_ph[r.button_index];
		o.held_time = btn_tmr[r.button_index];
		return o;
	endfunction

	function automatic req_t beat(input logic [2:0] op, input logic [6:0] key,
			input logic down, input logic [3:0] bi, input logic [15:0] dt,
			input logic [31:0] thr, input logic [15:0] m);
		req_t r;
		r.operation = op;
		r.key_code = key;
		r.is_pressed = down;
		r.button_index = bi;
		r.elapsed_time = dt;
		r.hold_threshold = thr;
		r.binding_mask = m;
		return r;
	endfunction

	function automatic rsp_t outcome(input logic c, input phase_t p, input logic [31:0] t);
		rsp_t o;
		o.consumed = c;
		o.button_phase = p;
		o.held_time = t;
		return o;
	endfunction

	function automatic void add_known(input req_t b, input rsp_t w);
		script.push_back('{beat: b, reps: 1, typed: 1'b1, want: w});
	endfunction

	function automatic void add_step(input req_t b, input int n);
		script.push_back('{beat: b, reps: n, typed: 1'b0, want: '0});
	endfunction

	function automatic req_t junk();
		req_t j;
		j.operation = $urandom_range(0, 7);
		j.key_code = $urandom_range(0, 127);
		j.is_pressed = $urandom_range(0, 1);
		j.button_index = $urandom_range(0, 15);
		j.elapsed_time = $urandom_range(0, 16'hffff);
		j.hold_threshold = $urandom;
		j.binding_mask = $urandom_range(0, 16'hffff);
		return j;
	endfunction

	function automatic logic [6:0] hot_key(input logic [6:0] fallback);
		if ($urandom_range(0, 99) < 85)
			return hot_keys[$urandom_range(0, 7)];
		return fallback;
	endfunction

	function automatic int button_in(input phase_t ph);
		int start;
		start = $urandom_range(0, NUM_BUTTONS - 1);
		for (int k = 0; k < NUM_BUTTONS; k++)
			if (btn_ph[(start + k) % NUM_BUTTONS] == ph)
				return (start + k) % NUM_BUTTONS;
		return -1;
	endfunction

	// mostly bind/press/release/tick traffic on a few keys, consumes aimed at live buttons
	function automatic req_t next_beat();
		req_t r;
		int unsigned pick;
		int b;
		r = junk();
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			r.operation = OP_BIND;
			r.key_code = hot_key(r.key_code);
			case ($urandom_range(0, 3))
			0: r.binding_mask = 16'h0001 << $urandom_range(0, 15);
			1: r.binding_mask = 16'h0003 << $urandom_range(0, 14);
			default: ;
			endcase
		end else if (pick < 45) begin
			r.operation = OP_KEY;
			r.key_code = hot_key(r.key_code);
		end else if (pick < 68) begin
			r.operation = OP_TICK;
			case ($urandom_range(0, 3))
			0: r.elapsed_time = $urandom_range(0, 15);
			1: r.elapsed_time = 16'hffff;
			default: ;
			endcase
		end else if (pick < 80) begin
			r.operation = OP_CPRESS;
			b = button_in(PH_JUST_PRESSED);
			if (b >= 0 && $urandom_range(0, 3) != 0)
				r.button_index = b;
		end else if (pick < 96) begin
			r.operation = OP_CRELEASE;
			b = button_in(PH_JUST_RELEASED);
			if (b >= 0 && $urandom_range(0, 3) != 0)
				r.button_index = b;
			// thresholds around the current timer hit both sides of the compare
			case ($urandom_range(0, 5))
			0: r.hold_threshold = '0;
			1: r.hold_threshold = btn_tmr[r.button_index];
			2: r.hold_threshold = btn_tmr[r.button_index] + 1;
			3: r.hold_threshold = btn_tmr[r.button_index] - 1;
			4: r.hold_threshold = '1;
			default: ;
			endcase
		end else begin
			case ($urandom_range(0, 2))
			0: r.operation = OP_SPARE5;
			1: r.operation = OP_SPARE6;
			default: r.operation = OP_SPARE7;
			endcase
		end
		return r;
	endfunction

	task automatic send_beat(input req_t b, input bit typed, input rsp_t w);
		int gap;
		rsp_t p;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				req_valid <= 1'b0;
				req <= junk();
			end
		end
		@(negedge clk);
		req <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		p = apply_beat(b);
		due_rsp.push_back(typed ? w : p);
		burst_left--;
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s", $time, what);
	endtask

	always @(negedge clk) begin
		if (flow_left == 0) begin
			flow = flow_t'($urandom_range(0, 3));
			flow_left = $urandom_range(16, 96);
		end
		flow_left--;
		case (flow)
		FLOW_FREE:   rsp_stall <= 1'b0;
		FLOW_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
		FLOW_TOGGLE: rsp_stall <= ~rsp_stall;
		default:     rsp_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin : rsp_check
		rsp_t w;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsp.size() == 0) begin
				flag_mismatch($sformatf("response beat with nothing due: %h", rsp));
			end else begin
				w = due_rsp.pop_front();
				if (rsp.consumed !== w.consumed)
					flag_mismatch($sformatf("consumed %b, want %b", rsp.consumed, w.consumed));
				if (rsp.button_phase !== w.button_phase)
					flag_mismatch($sformatf("button_phase %0d, want %0d",
						rsp.button_phase, w.button_phase));
				if (rsp.held_time !== w.held_time)
					flag_mismatch($sformatf("held_time %h, want %h",
						rsp.held_time, w.held_time));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("button_edge_hold_tracker: mismatch");
			$finish;
		end
	end

	initial begin : main
		rsp_t at_rest;
		at_rest = outcome(1'b0, PH_IDLE, 32'd0);
		foreach (bind_tab[k])
			bind_tab[k] = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			btn_ph[b] = PH_IDLE;
			btn_cnt[b] = '0;
			btn_tmr[b] = '0;
		end
		foreach (hot_keys[k])
			hot_keys[k] = $urandom_range(0, 127);

		// fresh block: nothing to consume, ticks and unbound keys do nothing
		add_known(beat(OP_CPRESS, 7'd0, 1'b1, 4'd0, 16'h0, 32'h0, 16'h0), at_rest);
		add_known(beat(OP_CRELEASE, 7'd0, 1'b0, 4'd15, 16'h0, 32'h0, 16'h0), at_rest);
		add_known(beat(OP_TICK, 7'd0, 1'b0, 4'd7, 16'hffff, 32'h0, 16'h0), at_rest);
		add_known(beat(OP_KEY, 7'd0, 1'b0, 4'd3, 16'h0, 32'h0, 16'h0), at_rest);
		add_known(beat(OP_SPARE5, 7'd127, 1'b1, 4'd15, 16'hffff, '1, 16'hffff), at_rest);
		add_known(beat(OP_SPARE6, 7'd127, 1'b1, 4'd15, 16'hffff, '1, 16'hffff), at_rest);
		add_known(beat(OP_SPARE7, 7'd127, 1'b1, 4'd15, 16'hffff, '1, 16'hffff), at_rest);
		add_known(beat(OP_BIND, 7'd0, 1'b0, 4'd0, 16'h0, 32'h0, 16'hffff), at_rest);
		add_known(beat(OP_BIND, 7'd127, 1'b0, 4'd15, 16'h0, 32'h0, 16'h8001), at_rest);
		add_known(beat(OP_KEY, 7'd127, 1'b1, 4'd15, 16'h0, 32'h0, 16'h0),
			outcome(1'b0, PH_JUST_PRESSED, 32'd0));
		// buttons 0 and 15 run into the count ceiling here
		add_step(beat(OP_KEY, 7'd0, 1'b1, 4'd0, 16'h0, 32'h0, 16'h0), 15);
		add_step(beat(OP_KEY, 7'd0, 1'b0, 4'd0, 16'h0, 32'h0, 16'h0), 14);
		add_known(beat(OP_CPRESS, 7'd0, 1'b0, 4'd15, 16'h0, 32'h0, 16'h0),
			outcome(1'b1, PH_HELD, 32'd0));
		add_known(beat(OP_CPRESS, 7'd0, 1'b0, 4'd15, 16'h0, 32'h0, 16'h0),
			outcome(1'b0, PH_HELD, 32'd0));
		add_step(beat(OP_TICK, 7'd0, 1'b0, 4'd0, 16'h0, 32'h0, 16'h0), 1);
		// a few long ticks build every held timer up to HOLD_TIME
		add_step(beat(OP_TICK, 7'd0, 1'b0, 4'd3, 16'hffff, 32'h0, 16'h0), HOLD_TICKS);
		add_step(beat(OP_KEY, 7'd0, 1'b0, 4'd3, 16'h0, 32'h0, 16'h0), 1);
		add_known(beat(OP_CRELEASE, 7'd0, 1'b0, 4'd3, 16'h0, HOLD_TIME, 16'h0),
			outcome(1'b1, PH_IDLE, 32'd0));
		add_known(beat(OP_CRELEASE, 7'd0, 1'b0, 4'd0, 16'h0, 32'h0, 16'h0),
			outcome(1'b1, PH_IDLE, 32'd0));
		add_known(beat(OP_CRELEASE, 7'd0, 1'b0, 4'd15, 16'h0, HOLD_TIME, 16'h0),
			outcome(1'b1, PH_IDLE, 32'd0));
		add_known(beat(OP_KEY, 7'd127, 1'b0, 4'd15, 16'h0, 32'h0, 16'h0), at_rest);
		add_known(beat(OP_TICK, 7'd0, 1'b0, 4'd7, 16'h1, 32'h0, 16'h0), at_rest);
		add_known(beat(OP_BIND, 7'd0, 1'b0, 4'd0, 16'h0, 32'h0, 16'h0), at_rest);
		add_known(beat(OP_BIND, 7'd127, 1'b0, 4'd0, 16'h0, 32'h0, 16'h0), at_rest);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			repeat (script[i].reps)
				send_beat(script[i].beat, script[i].typed, script[i].want);
		for (int n = 0; n < RANDOM_BEATS; n++)
			send_beat(next_beat(), 1'b0, '0);
		@(negedge clk);
		req_valid <= 1'b0;

		while (due_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("button_edge_hold_tracker: match");
		else
			$display("button_edge_hold_tracker: mismatch");
		$finish;
	end

endmodule

// ===== button_edge_hold_tracker.f =====
design/bet_pkg.sv
design/bet_ram.sv
design/bet_ctrl.sv
design/bet_dp.sv
design/button_edge_hold_tracker.sv
tb/sv/tb_button_edge_hold_tracker.sv
